// ===== hdl/poly_seeded_inverse_sqrt_top_macros.svh =====
// Assertion macros shared by the inverse square root RTL.
// Included by files that carry concurrent assertions.
`ifndef POLY_SEEDED_INVERSE_SQRT_TOP_MACROS_SVH
`define POLY_SEEDED_INVERSE_SQRT_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PSIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PSIS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/psis_pkg.sv =====
// Types and constants for the polynomial-seeded inverse square root.
// No dependencies.
`timescale 1ns / 1ps
package psis_pkg;
    localparam int DataW = 32;
    localparam int NumCoeffRegs = 6;
    localparam logic [2:0] RegIdxCoeff0 = 3'd0;
    localparam logic [2:0] RegIdxCoeff1 = 3'd1;
    localparam logic [2:0] RegIdxCount = 3'd6;
    localparam logic [2:0] RegIdxSteps = 3'd7;
    localparam logic signed [33:0] Q24Three = 34'sd50331648;
    localparam logic signed [63:0] QMax = 64'sd2147483647;
    localparam logic signed [63:0] QMin = -64'sd2147483648;

    // post ops of a multiply stage: none, add addend, three minus, halve
    localparam logic [1:0] OpNone = 2'd0;
    localparam logic [1:0] OpAdd = 2'd1;
    localparam logic [1:0] OpSub3 = 2'd2;
    localparam logic [1:0] OpHalf = 2'd3;

    // Work item carried between stages
    typedef struct packed {
        logic [31:0]        x;
        logic signed [31:0] y;
        logic               sat;
        logic               inv;
    } t_item;

    // Clamp a 64-bit value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                                 output logic hit);
        begin
            hit = 1'b0;
            if (v > QMax) begin
                hit = 1'b1;
                sat32 = 32'sh7fffffff;
            end else if (v < QMin) begin
                hit = 1'b1;
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction
endpackage

// ===== hdl/psis_mulstage.sv =====
// One pipeline stage: registered multiply with shift, clamp and a post op.
// Depends on psis_pkg.
`timescale 1ns / 1ps
module psis_mulstage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  psis_pkg::t_item       i_item,
    input  logic signed [32:0]    i_a,
    input  logic signed [32:0]    i_b,
    input  logic [4:0]            i_shift,
    input  logic [1:0]            i_op,
    input  logic signed [31:0]    i_addend,
    input  logic                  i_act,
    output logic                  o_vld,
    output psis_pkg::t_item       o_item,
    output logic signed [31:0]    o_val
);
    logic signed [65:0] w_prod;
    logic signed [63:0] w_sh;
    logic signed [31:0] w_m, w_r;
    logic signed [63:0] w_post;
    logic               w_h1, w_h2;

    assign w_prod = i_a * i_b;
    assign w_sh = 64'(w_prod >>> i_shift);

    always_comb begin
        w_m = psis_pkg::sat32(w_sh, w_h1);
        w_h2 = 1'b0;
        w_post = 64'(w_m);
        case (i_op)
            psis_pkg::OpAdd:  w_post = 64'(w_m) + 64'(i_addend);
            psis_pkg::OpSub3: w_post = 64'(psis_pkg::Q24Three) - 64'(w_m);
            psis_pkg::OpHalf: w_post = 64'(w_m) >>> 1;
            default: w_post = 64'(w_m);
        endcase
        w_r = psis_pkg::sat32(w_post, w_h2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    // inactive or invalid items pass through with y unchanged
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_act && !i_item.inv) begin
                o_item <= '{x: i_item.x, y: i_item.y,
                            sat: i_item.sat | w_h1 | w_h2, inv: i_item.inv};
                o_val  <= w_r;
            end else begin
                o_item <= i_item;
                o_val  <= i_item.y;
            end
        end
    end
endmodule

// ===== hdl/poly_seeded_inverse_sqrt_top.sv =====
// Top level of the polynomial-seeded inverse square root pipeline.
// Depends on psis_pkg, psis_mulstage and the assertion macro header.
//
// Usage: operands arrive on the s_axis channel (tdata = operand, unsigned
// Q16.16). Results leave on m_axis: tdata = root_inverse (signed Q8.24),
// tuser bit 0 = invalid, bit 1 = saturated. Coefficients, coefficient count
// and Newton step count are written through the plain write port while idle.
// The pipeline holds at most one multiply per stage: 2*(MAX_COEFFS-1) Horner stages
// plus 4*MAX_NEWTON_STEPS Newton stages, 38 register stages at the defaults.
// An operand is taken every cycle while s_axis_tready is high. Unused stages
// pass the item through. When the receiver stalls the whole pipeline holds;
// s_axis_tready drops only while the last stage holds a stalled result.
// Reset clears all valid bits and loads the register reset values. A zero
// operand returns 0 with invalid set.
`timescale 1ns / 1ps
`include "poly_seeded_inverse_sqrt_top_macros.svh"
module poly_seeded_inverse_sqrt_top #(
    parameter int MAX_COEFFS = 6,
    parameter int MAX_NEWTON_STEPS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] root_inverse
    output logic [1:0]  m_axis_tuser,   // [0] invalid, [1] saturated
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int HPairs = MAX_COEFFS - 1;
    localparam int NB = HPairs + MAX_NEWTON_STEPS + 1;

    logic signed [31:0] r_coeff [psis_pkg::NumCoeffRegs];
    logic [2:0] r_count, r_steps;
    logic [2:0] w_n, w_s;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psis_pkg::NumCoeffRegs; i++) r_coeff[i] <= '0;
            r_count <= 3'd1;
            r_steps <= 3'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == psis_pkg::RegIdxCount) r_count <= i_cfg_data[2:0];
            else if (i_cfg_idx == psis_pkg::RegIdxSteps) r_steps <= i_cfg_data[2:0];
            else r_coeff[i_cfg_idx] <= i_cfg_data;
        end
    end

    // clamp the counts
    always_comb begin
        w_n = (r_count == 3'd0) ? 3'd1 : r_count;
        if (32'(w_n) > MAX_COEFFS) w_n = 3'(MAX_COEFFS);
        w_s = (32'(r_steps) > MAX_NEWTON_STEPS) ? 3'(MAX_NEWTON_STEPS) : r_steps;
    end

    logic w_en;
    logic w_zero;
    logic            v_vld  [NB];
    psis_pkg::t_item v_item [NB];

    assign w_en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = w_en;

    // stage 0: seed with the highest used coefficient
    assign w_zero = (s_axis_tdata == '0);
    assign v_vld[0] = s_axis_tvalid;
    assign v_item[0] = '{x: s_axis_tdata,
                         y: w_zero ? 32'sd0 : r_coeff[w_n - 3'd1],
                         sat: 1'b0, inv: w_zero};

    // Horner: stage pair k handles coefficient index j = MAX_COEFFS-2-k
    for (genvar k = 0; k < HPairs; k++) begin : g_hor
        localparam int J = MAX_COEFFS - 2 - k;
        logic               w_act;
        logic               w_v1;
        psis_pkg::t_item    w_i1;
        logic signed [31:0] w_val;
        logic               r_vld;
        psis_pkg::t_item    r_item;
        assign w_act = (J < 32'(w_n) - 1);
        psis_mulstage u_h (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(v_vld[k]), .i_item(v_item[k]),
            .i_a(33'(v_item[k].y)), .i_b({1'b0, v_item[k].x}),
            .i_shift(5'd16), .i_op(psis_pkg::OpAdd), .i_addend(r_coeff[J]),
            .i_act(w_act),
            .o_vld(w_v1), .o_item(w_i1), .o_val(w_val)
        );
        // balance register, keeps one multiply per stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (w_en) begin
                r_vld <= w_v1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_item <= '{x: w_i1.x, y: w_val, sat: w_i1.sat, inv: w_i1.inv};
            end
        end
        assign v_vld[k+1] = r_vld;
        assign v_item[k+1] = r_item;
    end

    // Newton: four stages per step, s, p and t, q, then y
    for (genvar m = 0; m < MAX_NEWTON_STEPS; m++) begin : g_nwt
        localparam int B = HPairs + m;
        logic               w_act;
        logic signed [31:0] w_s_val, w_t_val, w_q;
        psis_pkg::t_item    w_i1, w_i2, w_i3;
        logic               w_v1, w_v2, w_v3;
        logic               r_vld;
        psis_pkg::t_item    r_item;
        assign w_act = (m < 32'(w_s));
        // s = sat(y*y >> 24)
        psis_mulstage u_s (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(v_vld[B]), .i_item(v_item[B]),
            .i_a(33'(v_item[B].y)), .i_b(33'(v_item[B].y)),
            .i_shift(5'd24), .i_op(psis_pkg::OpNone), .i_addend('0), .i_act(w_act),
            .o_vld(w_v1), .o_item(w_i1), .o_val(w_s_val)
        );
        // t = sat(3 - sat(x*s >> 16))
        psis_mulstage u_p (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(w_v1), .i_item(w_i1),
            .i_a({1'b0, w_i1.x}), .i_b(33'(w_s_val)),
            .i_shift(5'd16), .i_op(psis_pkg::OpSub3), .i_addend('0), .i_act(w_act),
            .o_vld(w_v2), .o_item(w_i2), .o_val(w_t_val)
        );
        // y = sat(y*t >> 24) >> 1, y rides unchanged in the item
        psis_mulstage u_q (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(w_v2), .i_item(w_i2),
            .i_a(33'(w_i2.y)), .i_b(33'(w_t_val)),
            .i_shift(5'd24), .i_op(psis_pkg::OpHalf), .i_addend('0), .i_act(w_act),
            .o_vld(w_v3), .o_item(w_i3), .o_val(w_q)
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (w_en) begin
                r_vld <= w_v3;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_item <= '{x: w_i3.x, y: w_q, sat: w_i3.sat, inv: w_i3.inv};
            end
        end
        assign v_vld[B+1] = r_vld;
        assign v_item[B+1] = r_item;
    end

    assign m_axis_tvalid = v_vld[NB-1];
    assign m_axis_tdata  = v_item[NB-1].y;
    assign m_axis_tuser  = {v_item[NB-1].sat, v_item[NB-1].inv};

    `PSIS_ASSERT_IMP(a_inv_zero, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0 && !m_axis_tuser[1])
    `PSIS_ASSERT_NXT(a_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `PSIS_ASSERT_IMP(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
endmodule

// ===== dv/poly_seeded_inverse_sqrt_top_test.sv =====
// Self-checking bench for the polynomial-seeded inverse square root pipeline.
// Depends on psis_pkg and poly_seeded_inverse_sqrt_top; predicts each result in place.
`timescale 1ns / 1ps
module poly_seeded_inverse_sqrt_top_test;
    localparam int SettleCycles = 60;
    localparam int WatchdogLimit = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // [31:0] operand
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] root_inverse
    logic [1:0]  m_axis_tuser;     // [0] invalid, [1] saturated
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    typedef struct packed {
        logic [31:0] root;
        logic        inv;
        logic        sat;
    } t_rsqrt;

    typedef struct {
        logic [31:0] operand;
        logic        known;
        t_rsqrt      res;
    } t_row;

    // Local copy of the register file
    logic signed [31:0] coef_m [psis_pkg::NumCoeffRegs];
    logic [2:0]         count_m;
    logic [2:0]         steps_m;

    t_rsqrt      pending_q[$];
    t_row        dir_rows[$];
    t_rsqrt      none;
    t_rsqrt      zero_res;
    int          errors;
    int          sent;
    int          got;
    int          idle_cycles;
    int          src_idle_pct;
    int          dst_idle_pct;

    poly_seeded_inverse_sqrt_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] floor_sh(input logic signed [63:0] v,
                                                  input int s);
        floor_sh = v >>> s;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                   inout logic hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            clamp32 = 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            hit = 1'b1;
            clamp32 = -64'sd2147483648;
        end else begin
            clamp32 = v;
        end
    endfunction

    // Horner seed followed by Newton refinement, Q8.24 with clamping
    function automatic t_rsqrt inv_sqrt_predict(input logic [31:0] op);
        logic signed [63:0] x, y, s, p, t, q;
        logic hit;
        int n;
        t_rsqrt r;
        hit = 1'b0;
        if (op == 0) begin
            r.root = '0;
            r.inv = 1'b1;
            r.sat = 1'b0;
            return r;
        end
        x = {32'd0, op};
        n = (count_m < 1) ? 1 : ((count_m > 6) ? 6 : int'(count_m));
        y = coef_m[n-1];
        for (int i = n - 1; i > 0; i--) begin
            y = clamp32(floor_sh(y * x, 16), hit);
            y = clamp32(y + coef_m[i-1], hit);
        end
        for (int i = 0; i < int'(steps_m); i++) begin
            s = clamp32(floor_sh(y * y, 24), hit);
            p = clamp32(floor_sh(x * s, 16), hit);
            t = clamp32(64'sd50331648 - p, hit);
            q = clamp32(floor_sh(y * t, 24), hit);
            y = floor_sh(q, 1);
        end
        r.root = y[31:0];
        r.inv = 1'b0;
        r.sat = hit;
        return r;
    endfunction

    // Register write; only issued while the pipeline is empty
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx < psis_pkg::NumCoeffRegs) coef_m[idx] = val;
        else if (idx == psis_pkg::RegIdxCount) count_m = val[2:0];
        else steps_m = val[2:0];
    endtask

    task automatic drain_pipe();
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // One operand transfer; expectation queued at acceptance
    task automatic send_operand(input logic [31:0] op, input logic known,
                                input t_rsqrt res);
        t_rsqrt e;
        while ($urandom_range(99) < src_idle_pct) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = op;
        e = known ? res : inv_sqrt_predict(op);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_q = {pending_q, e};
        sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Stimulus table helpers
    task automatic add_row(input logic [31:0] op, input logic known, input t_rsqrt res);
        t_row row;
        row.operand = op;
        row.known = known;
        row.res = res;
        dir_rows = {dir_rows, row};
    endtask

    task automatic run_rows();
        foreach (dir_rows[k])
            send_operand(dir_rows[k].operand, dir_rows[k].known, dir_rows[k].res);
        dir_rows.delete();
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_rsqrt e;
            got++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result root=%h flags=%b", $time,
                         m_axis_tdata, m_axis_tuser);
            end else begin
                e = pending_q.pop_front();
                if (m_axis_tdata !== e.root || m_axis_tuser[0] !== e.inv
                        || m_axis_tuser[1] !== e.sat) begin
                    errors++;
                    $display("%0t: mismatch expected root=%h inv=%b sat=%b,",
                             $time, e.root, e.inv, e.sat,
                             " got root=%h inv=%b sat=%b",
                             m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
                end
            end
        end
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Watchdog on transfer-free cycles
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(4))
            0: rand_operand = $urandom_range(32'h0002_0000, 32'h0000_4000);
            1: rand_operand = $urandom_range(32'h0010_0000, 32'h0000_2000);
            2: rand_operand = $urandom >> $urandom_range(31);
            3: rand_operand = $urandom_range(3);
            default: rand_operand = $urandom;
        endcase
    endfunction

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        errors = 0;
        sent = 0;
        got = 0;
        idle_cycles = 0;
        src_idle_pct = 14;
        dst_idle_pct = 56;
        none = '0;
        zero_res = '{root: 32'd0, inv: 1'b1, sat: 1'b0};
        for (int i = 0; i < psis_pkg::NumCoeffRegs; i++) coef_m[i] = '0;
        count_m = 3'd1;
        steps_m = 3'd2;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: after reset the seed is zero, so every valid x gives 0
        add_row(32'd0, 1'b1, zero_res);
        add_row(32'h0001_0000, 1'b1, t_rsqrt'{32'd0, 1'b0, 1'b0});
        add_row(32'hffff_ffff, 1'b1, t_rsqrt'{32'd0, 1'b0, 1'b0});
        add_row(32'd1, 1'b1, t_rsqrt'{32'd0, 1'b0, 1'b0});
        run_rows();
        drain_pipe();

        // Directed: linear seed 1.5 - 0.5x with three Newton steps
        write_reg(psis_pkg::RegIdxCoeff0, 32'h0180_0000);
        write_reg(psis_pkg::RegIdxCoeff1, 32'hff80_0000);
        write_reg(psis_pkg::RegIdxCount, 32'd2);
        write_reg(psis_pkg::RegIdxSteps, 32'd3);
        add_row(32'h0001_0000, 1'b0, none);
        add_row(32'h0000_8000, 1'b0, none);
        add_row(32'h0004_0000, 1'b0, none);
        add_row(32'hffff_ffff, 1'b0, none);
        add_row(32'd1, 1'b0, none);
        add_row(32'd0, 1'b1, zero_res);
        add_row(32'h0002_0000, 1'b0, none);
        run_rows();
        drain_pipe();

        // Directed: extreme coefficients, oversized count, most steps
        for (int i = 0; i < psis_pkg::NumCoeffRegs; i++)
            write_reg(i[2:0], (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff);
        write_reg(psis_pkg::RegIdxCount, 32'd7);
        write_reg(psis_pkg::RegIdxSteps, 32'd7);
        add_row(32'd1, 1'b0, none);
        add_row(32'hffff_ffff, 1'b0, none);
        add_row(32'h0001_0000, 1'b0, none);
        run_rows();
        drain_pipe();

        // Directed: zero count and zero steps
        write_reg(psis_pkg::RegIdxCount, 32'd0);
        write_reg(psis_pkg::RegIdxSteps, 32'd0);
        add_row(32'h0001_0000, 1'b0, none);
        add_row(32'd0, 1'b1, zero_res);
        run_rows();
        drain_pipe();

        // Random phases across register settings and idling modes
        for (int ph = 0; ph < 12; ph++) begin
            src_idle_pct = (ph < 4) ? 14 : (ph < 8) ? 56 : 0;
            dst_idle_pct = (ph < 4) ? 56 : (ph < 8) ? 14 : 0;
            for (int i = 0; i < psis_pkg::NumCoeffRegs; i++)
                write_reg(i[2:0], ($urandom_range(3) == 0) ? $urandom
                          : 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000));
            write_reg(psis_pkg::RegIdxCount, $urandom_range(7));
            write_reg(psis_pkg::RegIdxSteps, $urandom_range(7));
            for (int k = 0; k < 104; k++) begin
                if (k == 50) drain_pipe();
                send_operand(rand_operand(), 1'b0, none);
            end
            drain_pipe();
        end

        $display("Ran %0d operands through reset, directed and random register setups",
                 sent);
        $display("with sender and receiver stalls; %0d results compared.", got);
        if (errors == 0 && pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/psis_pkg.sv
hdl/psis_mulstage.sv
hdl/poly_seeded_inverse_sqrt_top.sv
dv/poly_seeded_inverse_sqrt_top_test.sv
